[rtl/core/swsnd_pkg.sv]
// Shared types, codes and the control program of the sliding window sender.
package swsnd_pkg;

  // Default sizing and the fixed limits of the protocol.
  localparam int DEF_RING_DEPTH = 16;
  localparam int DEF_MAX_CHUNK  = 1024;
  localparam int WIN_MAX        = 16;
  localparam int EOF_MAX        = 32;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 11;
  localparam int SEQ_W   = 32;
  localparam int PEND_W  = 5;
  localparam int WL_W    = 5;
  localparam int REP_W   = 6;
  localparam int STEP_W  = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register reset values.
  localparam logic [WL_W-1:0]  WIN_RESET = WL_W'(10);
  localparam logic [REP_W-1:0] REP_RESET = REP_W'(21);

  // Register indexes, taken from paddr[2].
  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic REG_END_REPEATS  = 1'b1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  // Result actions.
  typedef enum logic [3:0] {
    ACT_SEND         = 4'd0,
    ACT_RESEND       = 4'd1,
    ACT_SEND_EOF     = 4'd2,
    ACT_FULL         = 4'd3,
    ACT_ACK_OK       = 4'd4,
    ACT_ACK_IGNORED  = 4'd5,
    ACT_EOF_NOTED    = 4'd6,
    ACT_IGNORED      = 4'd7,
    ACT_IDLE_TIMEOUT = 4'd8
  } action_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  chunk_len;
    logic [SEQ_W-1:0]  ack_number;
  } item_t;

  typedef struct packed {
    action_t           action;
    logic [SEQ_W-1:0]  seq_number;
    logic [LEN_W-1:0]  length;
    logic [PEND_W-1:0] outstanding;
    logic              last;
  } result_t;

  // Datapath operations of one step.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEND,
    OP_NOTE,
    OP_ACK_MORE,
    OP_ACK_LAST,
    OP_FIN_ACK,
    OP_FIN_EOF,
    OP_WALK
  } uop_t;

  typedef enum logic [1:0] {SSEL_ZERO, SSEL_NEXT, SSEL_RING} seq_sel_t;
  typedef enum logic [1:0] {LSEL_ZERO, LSEL_INPUT, LSEL_RING} len_sel_t;
  typedef enum logic {LAST_ALWAYS, LAST_ON_COUNT_ONE} last_sel_t;
  typedef enum logic {RA_NEXT_OLDEST, RA_WALK} raddr_sel_t;
  typedef enum logic [1:0] {FLOW_DISPATCH, FLOW_JUMP, FLOW_LOOP} flow_t;

  typedef struct packed {
    uop_t              op;
    logic              emit;
    action_t           act;
    seq_sel_t          seq_sel;
    len_sel_t          len_sel;
    last_sel_t         last_sel;
    logic              cnt_dec;
    raddr_sel_t        raddr_sel;
    flow_t             flow;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_IGNORE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FULL     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ACK_IGN  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_IDLE_TO  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_NOTE     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SEND     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ACK_MORE = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ACK_LAST = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIN_ACK  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FIN_EOF  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EOF_LOOP = 4'd11;
  localparam logic [STEP_W-1:0] STEP_TO_PRIME = 4'd12;
  localparam logic [STEP_W-1:0] STEP_TO_LOOP  = 4'd13;

  // The control store: one control word for each program address.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w.op        = OP_NONE;
    w.emit      = 1'b0;
    w.act       = ACT_IGNORED;
    w.seq_sel   = SSEL_ZERO;
    w.len_sel   = LSEL_ZERO;
    w.last_sel  = LAST_ALWAYS;
    w.cnt_dec   = 1'b0;
    w.raddr_sel = RA_NEXT_OLDEST;
    w.flow      = FLOW_JUMP;
    w.target    = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.flow = FLOW_DISPATCH;
      end
      STEP_IGNORE: begin
        w.emit = 1'b1;
        w.act  = ACT_IGNORED;
      end
      STEP_FULL: begin
        w.emit = 1'b1;
        w.act  = ACT_FULL;
      end
      STEP_ACK_IGN: begin
        w.emit = 1'b1;
        w.act  = ACT_ACK_IGNORED;
      end
      STEP_IDLE_TO: begin
        w.emit = 1'b1;
        w.act  = ACT_IDLE_TIMEOUT;
      end
      STEP_NOTE: begin
        w.op   = OP_NOTE;
        w.emit = 1'b1;
        w.act  = ACT_EOF_NOTED;
      end
      STEP_SEND: begin
        w.op      = OP_SEND;
        w.emit    = 1'b1;
        w.act     = ACT_SEND;
        w.seq_sel = SSEL_NEXT;
        w.len_sel = LSEL_INPUT;
      end
      STEP_ACK_MORE: begin
        w.op   = OP_ACK_MORE;
        w.emit = 1'b1;
        w.act  = ACT_ACK_OK;
      end
      STEP_ACK_LAST: begin
        w.op   = OP_ACK_LAST;
        w.emit = 1'b1;
        w.act  = ACT_ACK_OK;
      end
      STEP_FIN_ACK: begin
        w.op     = OP_FIN_ACK;
        w.target = STEP_EOF_LOOP;
      end
      STEP_FIN_EOF: begin
        w.op     = OP_FIN_EOF;
        w.target = STEP_EOF_LOOP;
      end
      STEP_EOF_LOOP: begin
        w.emit     = 1'b1;
        w.act      = ACT_SEND_EOF;
        w.seq_sel  = SSEL_NEXT;
        w.last_sel = LAST_ON_COUNT_ONE;
        w.cnt_dec  = 1'b1;
        w.flow     = FLOW_LOOP;
      end
      STEP_TO_PRIME: begin
        w.op        = OP_WALK;
        w.raddr_sel = RA_WALK;
        w.target    = STEP_TO_LOOP;
      end
      STEP_TO_LOOP: begin
        w.op        = OP_WALK;
        w.raddr_sel = RA_WALK;
        w.emit      = 1'b1;
        w.act       = ACT_RESEND;
        w.seq_sel   = SSEL_RING;
        w.len_sel   = LSEL_RING;
        w.last_sel  = LAST_ON_COUNT_ONE;
        w.cnt_dec   = 1'b1;
        w.flow      = FLOW_LOOP;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/sliding_window_sender.sv]
// Go-back-N sender bookkeeping: a microcoded sequencer over a ring of chunk records.
// An item is taken when start is high and busy low; a timeout or end of file runs a setup
// step (TO_PRIME, FIN_EOF or FIN_ACK) before its first result.
// Data, ack and single-result items give one result; a timeout resends each of the N chunks
// outstanding, and end of file sends R copies, whether it comes with the item or
// with the last ack. Results come one a cycle and cannot be stalled.
// Synchronous reset clears control state and presets registers; the ring is left undefined.
module sliding_window_sender #(
  parameter int RING_DEPTH = swsnd_pkg::DEF_RING_DEPTH,
  parameter int MAX_CHUNK  = swsnd_pkg::DEF_MAX_CHUNK
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swsnd_pkg::APB_AW-1:0]        paddr,
  input  logic [swsnd_pkg::APB_DW-1:0]        pwdata,
  output logic [swsnd_pkg::APB_DW-1:0]        prdata,
  output logic                                pready,
  input  logic                                start,
  input  swsnd_pkg::item_t                    item,
  output logic                                busy,
  output logic                                result_valid,
  output swsnd_pkg::result_t                  result
);
  import swsnd_pkg::*;

  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int WinCeil = (RING_DEPTH < WIN_MAX) ? RING_DEPTH : WIN_MAX;
  localparam int LenCap  = (MAX_CHUNK > 2047) ? 2047 : MAX_CHUNK;
  localparam logic [WL_W-1:0]   WIN_CEIL_V = WL_W'(WinCeil);
  localparam logic [REP_W-1:0]  REP_CEIL_V = REP_W'(EOF_MAX);
  localparam logic [LEN_W-1:0]  LEN_CAP_V  = LEN_W'(LenCap);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RING_DEPTH - 1);
  localparam logic [REP_W-1:0]  COUNT_ONE  = REP_W'(1);
  localparam logic [PEND_W-1:0] PEND_CEIL_V = PEND_W'(WinCeil);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  // Configuration registers.
  logic [WL_W-1:0]  window_limit;
  logic [REP_W-1:0] end_repeats;

  // Ring of outstanding chunks.
  logic [SEQ_W-1:0] ring_seq [RING_DEPTH];
  logic [LEN_W-1:0] ring_len [RING_DEPTH];
  logic [SEQ_W-1:0] rd_seq;
  logic [LEN_W-1:0] rd_len;
  logic [SLOT_W-1:0] raddr;
  logic              wr_en;
  logic [SLOT_W-1:0] waddr;

  // Window state.
  logic [SLOT_W-1:0] oldest_slot, oldest_slot_next;
  logic [SLOT_W-1:0] newest_slot, newest_slot_next;
  logic [PEND_W-1:0] pending_count, pending_count_next;
  logic [SEQ_W-1:0]  next_seq, next_seq_next;
  logic [SEQ_W-1:0]  expected_ack, expected_ack_next;
  logic              expected_valid, expected_valid_next;
  logic              end_seen, end_seen_next;
  logic              finished, finished_next;

  // Sequencer and scratch registers.
  logic [STEP_W-1:0] upc, upc_next;
  logic [SLOT_W-1:0] walk_slot, walk_slot_next;
  logic [REP_W-1:0]  count, count_next;
  logic [LEN_W-1:0]  in_len;

  ctrl_word_t        cw;
  logic              accept;
  logic              ack_hit;
  logic [WL_W-1:0]   win_eff;
  logic [REP_W-1:0]  rep_eff;
  logic [LEN_W-1:0]  len_sat;
  logic [STEP_W-1:0] dispatch_step;
  logic              cfg_write;

  assign cw     = ucode(upc);
  assign busy   = (upc != STEP_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // Register port: writes complete in the access phase; reads return the stored value.
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_END_REPEATS) ? {{(APB_DW-REP_W){1'b0}}, end_repeats}
                                                : {{(APB_DW-WL_W){1'b0}}, window_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= WIN_RESET;
      end_repeats  <= REP_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WINDOW_LIMIT) begin
        window_limit <= pwdata[WL_W-1:0];
      end else begin
        end_repeats <= pwdata[REP_W-1:0];
      end
    end
  end

  // Effective limits with out-of-range settings clamped.
  always_comb begin
    if (window_limit == '0) begin
      win_eff = WL_W'(1);
    end else if (window_limit > WIN_CEIL_V) begin
      win_eff = WIN_CEIL_V;
    end else begin
      win_eff = window_limit;
    end
    if (end_repeats == '0) begin
      rep_eff = COUNT_ONE;
    end else if (end_repeats > REP_CEIL_V) begin
      rep_eff = REP_CEIL_V;
    end else begin
      rep_eff = end_repeats;
    end
  end

  assign len_sat = (item.chunk_len > LEN_CAP_V) ? LEN_CAP_V : item.chunk_len;
  assign ack_hit = expected_valid && (pending_count != '0) &&
                   (item.ack_number == expected_ack);

  // Dispatch: pick the routine entry for the incoming item.
  always_comb begin
    dispatch_step = STEP_IGNORE;
    if (!finished) begin
      case (item.kind)
        KIND_DATA: begin
          if (end_seen) begin
            dispatch_step = STEP_IGNORE;
          end else if (item.chunk_len == '0) begin
            dispatch_step = (pending_count == '0) ? STEP_FIN_EOF : STEP_NOTE;
          end else if (pending_count >= win_eff) begin
            dispatch_step = STEP_FULL;
          end else begin
            dispatch_step = STEP_SEND;
          end
        end
        KIND_ACK: begin
          if (!ack_hit) begin
            dispatch_step = STEP_ACK_IGN;
          end else if (pending_count == PEND_W'(1)) begin
            dispatch_step = end_seen ? STEP_FIN_ACK : STEP_ACK_LAST;
          end else begin
            dispatch_step = STEP_ACK_MORE;
          end
        end
        KIND_TIMEOUT: begin
          dispatch_step = (pending_count == '0) ? STEP_IDLE_TO : STEP_TO_PRIME;
        end
        default: begin
          dispatch_step = STEP_IGNORE;
        end
      endcase
    end
  end

  // Step sequencing.
  always_comb begin
    case (cw.flow)
      FLOW_DISPATCH: upc_next = accept ? dispatch_step : STEP_IDLE;
      FLOW_JUMP:     upc_next = cw.target;
      FLOW_LOOP:     upc_next = (count == COUNT_ONE) ? cw.target : upc;
      default:       upc_next = STEP_IDLE;
    endcase
  end

  // Datapath operations selected by the control word.
  always_comb begin
    oldest_slot_next    = oldest_slot;
    newest_slot_next    = newest_slot;
    pending_count_next  = pending_count;
    next_seq_next       = next_seq;
    expected_ack_next   = expected_ack;
    expected_valid_next = expected_valid;
    end_seen_next       = end_seen;
    finished_next       = finished;
    walk_slot_next      = walk_slot;
    count_next          = count;
    if (cw.flow == FLOW_DISPATCH && accept) begin
      walk_slot_next = oldest_slot;
      count_next     = {{(REP_W-PEND_W){1'b0}}, pending_count};
    end
    case (cw.op)
      OP_SEND: begin
        newest_slot_next   = slot_inc(newest_slot);
        next_seq_next      = next_seq + {{(SEQ_W-LEN_W){1'b0}}, in_len};
        pending_count_next = pending_count + 1'b1;
        if (!expected_valid) begin
          expected_ack_next   = next_seq + {{(SEQ_W-LEN_W){1'b0}}, in_len};
          expected_valid_next = 1'b1;
        end
      end
      OP_NOTE: begin
        end_seen_next = 1'b1;
      end
      OP_ACK_MORE: begin
        oldest_slot_next   = slot_inc(oldest_slot);
        pending_count_next = pending_count - 1'b1;
        expected_ack_next  = rd_seq + {{(SEQ_W-LEN_W){1'b0}}, rd_len};
      end
      OP_ACK_LAST: begin
        oldest_slot_next    = slot_inc(oldest_slot);
        pending_count_next  = pending_count - 1'b1;
        expected_ack_next   = '0;
        expected_valid_next = 1'b0;
      end
      OP_FIN_ACK: begin
        oldest_slot_next    = slot_inc(oldest_slot);
        pending_count_next  = pending_count - 1'b1;
        expected_ack_next   = '0;
        expected_valid_next = 1'b0;
        finished_next       = 1'b1;
        count_next          = rep_eff;
      end
      OP_FIN_EOF: begin
        end_seen_next = 1'b1;
        finished_next = 1'b1;
        count_next    = rep_eff;
      end
      OP_WALK: begin
        walk_slot_next = slot_inc(walk_slot);
      end
      default: begin
      end
    endcase
    if (cw.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc            <= STEP_IDLE;
      oldest_slot    <= '0;
      newest_slot    <= SLOT_LAST;
      pending_count  <= '0;
      next_seq       <= '0;
      expected_ack   <= '0;
      expected_valid <= 1'b0;
      end_seen       <= 1'b0;
      finished       <= 1'b0;
      walk_slot      <= '0;
      count          <= '0;
    end else begin
      upc            <= upc_next;
      oldest_slot    <= oldest_slot_next;
      newest_slot    <= newest_slot_next;
      pending_count  <= pending_count_next;
      next_seq       <= next_seq_next;
      expected_ack   <= expected_ack_next;
      expected_valid <= expected_valid_next;
      end_seen       <= end_seen_next;
      finished       <= finished_next;
      walk_slot      <= walk_slot_next;
      count          <= count_next;
    end
  end

  // The item's clamped length is held for the routine.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_len <= len_sat;
    end
  end

  // Ring memory: one write port, one registered read port.
  assign wr_en = (cw.op == OP_SEND);
  assign waddr = slot_inc(newest_slot);
  assign raddr = (cw.raddr_sel == RA_WALK) ? walk_slot : slot_inc(oldest_slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_seq[waddr] <= next_seq;
      ring_len[waddr] <= in_len;
    end
    rd_seq <= ring_seq[raddr];
    rd_len <= ring_len[raddr];
  end

  // Result register: each result is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit) begin
      result.action <= cw.act;
      case (cw.seq_sel)
        SSEL_NEXT: result.seq_number <= next_seq;
        SSEL_RING: result.seq_number <= rd_seq;
        default:   result.seq_number <= '0;
      endcase
      case (cw.len_sel)
        LSEL_INPUT: result.length <= in_len;
        LSEL_RING:  result.length <= rd_len;
        default:    result.length <= '0;
      endcase
      result.outstanding <= pending_count_next;
      result.last        <= (cw.last_sel == LAST_ALWAYS) || (count == COUNT_ONE);
    end
  end

  // Checks on the window bookkeeping and the sequencer.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= PEND_CEIL_V)
    else $error("more chunks outstanding than the ring window allows");

  a_expect_tracks: assert property (@(posedge clk) disable iff (rst)
    expected_valid == (pending_count != '0))
    else $error("expected ack validity out of step with the outstanding count");

  a_finish_empty: assert property (@(posedge clk) disable iff (rst)
    finished |-> (pending_count == '0))
    else $error("finished with chunks still outstanding");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("final result shown while the sequencer is still busy");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a routine running");

endmodule
